// ----- src/wod_pkg.sv -----
package wod_pkg;

    localparam int FREQ_W     = 20;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int WSEL_W     = 3;
    localparam int VOL_W      = 15;
    localparam int RATE_W     = 20;
    localparam int LEVEL_W    = 31;
    localparam int LFSR_W     = 16;

    localparam logic [VOL_W-1:0]   START_VOLUME_RST = 15'd8192;
    localparam logic [RATE_W-1:0]  RATE_STEP_RST    = 20'd6087;
    localparam logic [LFSR_W-1:0]  LFSR_SEED        = 16'hACE1;
    localparam logic [LFSR_W-1:0]  LFSR_MASK        = 16'hB400;

    // Decay by 0.9999 in Q32 is level - ceil(level * DECAY_C / 2^32).
    localparam logic [31:0] DECAY_C     = 32'd429496;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {START_VOLUME_RST | 15'h7FFF, 16'h0000};

    // Noise: k = lfsr mod 2000, value = (k * 32768 + 500) / 1000 - 32768.
    // The divide by 1000 is a multiply by ceil(2^36 / 1000) and a shift.
    localparam logic [16:0] NOISE_SPAN  = 17'd2000;
    localparam logic [25:0] NOISE_BIAS  = 26'd500;
    localparam logic [31:0] NOISE_RECIP = 32'd68719477;
    localparam int          NOISE_SHIFT = 36;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef enum logic [WSEL_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_NOISE    = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_SAW      = 3'd4,
        WAVE_REV_SAW  = 3'd5
    } wave_sel_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WAVE_SELECT  = 2'd0,
        REG_START_VOLUME = 2'd1,
        REG_RATE_STEP    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_DECAY,
        ST_NOISE,
        ST_SCALE,
        ST_OUT
    } state_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        r = v >> 1;
        if (v[0]) begin
            r = r ^ LFSR_MASK;
        end
        return r;
    endfunction

    // Remainder by 2000 of a 16-bit value; the quotient is at most 32.
    function automatic logic [10:0] noise_mod(input logic [LFSR_W-1:0] v);
        logic [16:0] r;
        r = {1'b0, v};
        for (int i = 5; i >= 0; i--) begin
            if (r >= (NOISE_SPAN << i)) begin
                r = r - (NOISE_SPAN << i);
            end
        end
        return r[10:0];
    endfunction

endpackage

// ----- src/waveform_oscillator_decay.sv -----
// Tone oscillator with six waveforms and a decaying volume envelope.
// Input channel (s_valid, s_ready, s_freq): one item per audio sample tick,
// carrying the tone frequency in 1/16 Hz. Output channel (m_valid, m_ready,
// m_sample): one signed 16-bit sample for each input item, in order.
// Configuration (cfg_wr_en, cfg_addr, cfg_wdata) sets the waveform, the
// start volume and the phase step; write it only while the block is idle.
// One 32x32 multiplier is shared by five steps: count times frequency,
// times phase step, the volume decay, the noise scaling and the final
// volume scaling. An accepted item goes through the phase, decay, noise,
// scale and output steps in order; s_ready stays low until the sample is
// loaded into the output register, so a new item is taken only after that.
// The sample sits in an output register, so a new item can be accepted
// while the receiver stalls; if a second sample is finished before the
// first is taken, the sequencer waits in its last step.
// Reset clears the sample counter, the envelope and the pending sample,
// restores the configuration defaults and reseeds the noise generator.
// The sine table is a registered ROM built from constants.
module waveform_oscillator_decay #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wod_pkg::FREQ_W-1:0]          s_freq,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wod_pkg::SAMPLE_W-1:0] m_sample,
    input  logic                                cfg_wr_en,
    input  logic [wod_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [wod_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import wod_pkg::*;

    state_t state_reg, state_next;

    logic [WSEL_W-1:0]  wave_sel_reg;
    logic [VOL_W-1:0]   start_vol_reg;
    logic [RATE_W-1:0]  rate_reg;

    logic [31:0]        count_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [FREQ_W-1:0]  prev_freq_reg;
    logic               prev_valid_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic [31:0]        phase_reg;
    logic [25:0]        noise_x_reg;
    logic               wave_neg_reg;
    logic               m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_sample_reg;

    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    logic signed [15:0] sine;
    logic               accept;
    logic               out_fire;
    logic               reload;
    logic [31:0]        dec_amt;
    logic [LEVEL_W-1:0] level_new;
    logic [LFSR_W-1:0]  lfsr_new;
    logic [25:0]        noise_x;
    logic [16:0]        tri_u;
    logic [15:0]        saw_h;
    logic signed [17:0] tri_v;
    logic signed [17:0] rev_v;
    logic signed [17:0] noise_v;
    logic signed [15:0] wave;
    logic [15:0]        wave_abs;
    logic [15:0]        mag;
    logic signed [SAMPLE_W-1:0] result;

    wod_mult u_mult (
        .clk  (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    wod_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .clk     (aclk),
        .rd_en   (state_reg == ST_DECAY),
        .rd_addr (prod[31 -: SINE_ADDR_BITS]),
        .rd_data (sine)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_fire = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    assign reload    = !prev_valid_reg || (freq_reg != prev_freq_reg);
    assign dec_amt   = prod[63:32] + {31'd0, |prod[31:0]};
    assign level_new = reload ? {start_vol_reg, 16'h0000} : (level_reg - dec_amt[LEVEL_W-1:0]);
    assign lfsr_new  = lfsr_step(lfsr_reg);
    assign noise_x   = {noise_mod(lfsr_new), 15'd0} + NOISE_BIAS;

    always_comb begin
        tri_u   = phase_reg[31:15];
        saw_h   = phase_reg[31:16];
        noise_v = $signed({2'b00, prod[NOISE_SHIFT +: 16]}) - 18'sd32768;
        rev_v   = 18'sd32768 - $signed({2'b00, saw_h});
        if (rev_v > 18'sd32767) begin
            rev_v = 18'sd32767;
        end
        if (tri_u < 17'd32768) begin
            tri_v = $signed({1'b0, tri_u});
        end else if (tri_u < 17'd98304) begin
            tri_v = 18'sd65536 - $signed({1'b0, tri_u});
            if (tri_v > 18'sd32767) begin
                tri_v = 18'sd32767;
            end
        end else begin
            tri_v = $signed({1'b0, tri_u}) - 18'sd131072;
        end
        case (wave_sel_reg)
            WAVE_SQUARE:   wave = (sine > 16'sd0) ? 16'sh7FFF : 16'sh8000;
            WAVE_NOISE:    wave = noise_v[15:0];
            WAVE_TRIANGLE: wave = tri_v[15:0];
            WAVE_SAW:      wave = $signed({~saw_h[15], saw_h[14:0]});
            WAVE_REV_SAW:  wave = rev_v[15:0];
            default:       wave = sine;
        endcase
        wave_abs = wave[15] ? 16'(-wave) : 16'(wave);
    end

    // The product is below 2^46, so the scaled magnitude never exceeds 32767.
    assign mag    = prod[46:31];
    assign result = wave_neg_reg ? -$signed(mag) : $signed(mag);

    always_comb begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = count_reg;
        mul_b      = {12'd0, s_freq};
        unique case (state_reg)
            ST_IDLE: begin
                mul_en = accept;
                if (accept) begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                mul_en     = 1'b1;
                mul_a      = prod[31:0];
                mul_b      = {12'd0, rate_reg};
                state_next = ST_DECAY;
            end
            ST_DECAY: begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, level_reg};
                mul_b      = DECAY_C;
                state_next = ST_NOISE;
            end
            ST_NOISE: begin
                mul_en     = 1'b1;
                mul_a      = {6'd0, noise_x_reg};
                mul_b      = NOISE_RECIP;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                mul_en     = 1'b1;
                mul_a      = {16'd0, wave_abs};
                mul_b      = {1'b0, level_reg};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_sel_reg  <= WAVE_SINE;
            start_vol_reg <= START_VOLUME_RST;
            rate_reg      <= RATE_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WAVE_SELECT:  wave_sel_reg  <= cfg_wdata[WSEL_W-1:0];
                REG_START_VOLUME: start_vol_reg <= cfg_wdata[VOL_W-1:0];
                REG_RATE_STEP:    rate_reg      <= cfg_wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= 32'd0;
            prev_freq_reg  <= '0;
            prev_valid_reg <= 1'b0;
            level_reg      <= '0;
            lfsr_reg       <= LFSR_SEED;
        end else if (state_reg == ST_NOISE) begin
            count_reg      <= (reload ? 32'd0 : count_reg) + 32'd1;
            prev_freq_reg  <= freq_reg;
            prev_valid_reg <= 1'b1;
            level_reg      <= level_new;
            if (wave_sel_reg == WAVE_NOISE) begin
                lfsr_reg <= lfsr_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            freq_reg <= s_freq;
        end
        if (state_reg == ST_DECAY) begin
            phase_reg   <= prod[31:0];
            noise_x_reg <= noise_x;
        end
        if (state_reg == ST_SCALE) begin
            wave_neg_reg <= wave[15];
        end
        if (out_fire) begin
            m_sample_reg <= result;
        end
    end

    a_fixed_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ##4 (state_reg == ST_OUT))
        else $error("item did not reach the output step in time");

    a_reload_restarts_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NOISE && reload) |=> (count_reg == 32'd1))
        else $error("sample counter not restarted on a new frequency");

    a_level_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_MAX)
        else $error("envelope level above the largest start volume");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("noise generator stuck at zero");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("sample presented outside the output step");

endmodule

// ----- src/wod_sine_rom.sv -----
module wod_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic signed [15:0]   rd_data
);
    import wod_pkg::*;

    localparam int          SIZE         = 1 << ADDR_BITS;
    localparam int          QUARTER_BITS = ADDR_BITS - 2;
    localparam logic [63:0] QUARTER      = 64'd1 << QUARTER_BITS;

    typedef logic signed [15:0] sine_tab_t [SIZE];

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic sine_tab_t build_table();
        sine_tab_t   tab;
        logic [63:0] idx;
        logic [63:0] j;
        logic [63:0] k;
        logic [63:0] ang;
        logic [63:0] s;
        for (int i = 0; i < SIZE; i++) begin
            idx = 64'(i);
            j   = idx & (QUARTER - 64'd1);
            k   = idx[QUARTER_BITS] ? (QUARTER - j) : j;
            ang = (HALF_PI_Q30 * k) >> QUARTER_BITS;
            s   = (sin_q30(ang) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            tab[i] = idx[QUARTER_BITS+1] ? -$signed(s[15:0]) : $signed(s[15:0]);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_table();

    logic signed [15:0] data_reg;

    always_ff @(posedge clk) begin
        if (rd_en) begin
            data_reg <= SINE_TAB[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

// ----- src/wod_mult.sv -----
module wod_mult (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);
    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = {32'd0, op_a} * {32'd0, op_b};

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
